/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the severity event log.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* rtl/sevlog_pkg.sv */
// Types and constants for the severity event log.
// No dependencies.
package sevlog_pkg;

   localparam int OP_W        = 2;
   localparam int SEV_W       = 2;
   localparam int TS_W        = 64;
   localparam int TAG_W       = 16;
   localparam int FILT_W      = 3;
   localparam int CNT_OUT_W   = 6;
   localparam int READOUT_CAP = 32;
   localparam int MATCH_W     = $clog2(READOUT_CAP + 1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD       = 2'd0,
      OP_READOUT   = 2'd1,
      OP_MARK_READ = 2'd2,
      OP_CLEAR     = 2'd3
   } opcode_type;

   localparam logic [SEV_W-1:0] SEV_INFO    = 2'd0;
   localparam logic [SEV_W-1:0] SEV_SUCCESS = 2'd1;
   localparam logic [SEV_W-1:0] SEV_WARNING = 2'd2;
   localparam logic [SEV_W-1:0] SEV_ERROR   = 2'd3;

   typedef struct packed {
      logic [TS_W-1:0]  timestamp;
      logic [SEV_W-1:0] severity;
      logic             modal;
      logic [TAG_W-1:0] tag;
   } rec_type;

endpackage

/* rtl/severity_event_log_ring_core.sv */
// Severity event log core: ring of records held in one synchronous memory.
// Depends on sevlog_pkg and assert_macros.svh.
//
//   channel  | handshake            | carries
//   ---------+----------------------+------------------------------------------
//   req_     | req_valid/req_ready  | opcode, new record fields, read filter
//   rsp_     | rsp_valid/rsp_ready  | one record or status marker, counts
//
// Add: memory read of the slot to be replaced, then write, then status.
// Mark read / clear: counts updated, then status. Readout: each held record
// scanned takes a memory read state and a check state, as the record memory
// read is registered, plus the request, the end check and the flush.
// One request is worked on at a time; a full output register stalls the scan.
// Reset empties the log at once; the record memory itself is not cleared.
`include "assert_macros.svh"

module severity_event_log_ring_core #(
   parameter int LOG_DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sevlog_pkg::OP_W-1:0]           req_opcode,
   input  logic [sevlog_pkg::TS_W-1:0]           req_new_timestamp,
   input  logic [sevlog_pkg::SEV_W-1:0]          req_new_severity,
   input  logic                                  req_new_modal,
   input  logic [sevlog_pkg::TAG_W-1:0]          req_new_tag,
   input  logic signed [sevlog_pkg::FILT_W-1:0]  req_read_filter,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_record_valid,
   output logic [sevlog_pkg::TS_W-1:0]           rsp_out_timestamp,
   output logic [sevlog_pkg::SEV_W-1:0]          rsp_out_severity,
   output logic                                  rsp_out_modal,
   output logic                                  rsp_out_read_flag,
   output logic [sevlog_pkg::TAG_W-1:0]          rsp_out_tag,
   output logic                                  rsp_last_of_run,
   output logic [sevlog_pkg::CNT_OUT_W-1:0]      rsp_stored_count,
   output logic [sevlog_pkg::CNT_OUT_W-1:0]      rsp_unread_count,
   output logic [sevlog_pkg::SEV_W-1:0]          rsp_highest_unread
);
   import sevlog_pkg::*;

   localparam int AW = $clog2(LOG_DEPTH);
   localparam int CW = $clog2(LOG_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(LOG_DEPTH);
   localparam logic [MATCH_W-1:0] CAP_CNT = MATCH_W'(READOUT_CAP);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_WR,
      S_STATUS,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FLUSH
   } state_type;

   state_type            state_ff;
   rec_type              rec_mem [LOG_DEPTH];
   rec_type              rd_data_ff;
   rec_type              new_rec_ff;
   rec_type              pend_rec_ff;
   logic                 pend_read_ff;
   logic                 pend_valid_ff;
   logic                 all_ff;
   logic [SEV_W-1:0]     want_ff;
   logic [AW-1:0]        wp_ff;
   logic [AW-1:0]        slot_ff;
   logic [CW-1:0]        held_ff;
   logic [CW-1:0]        unread_ff;
   logic [CW-1:0]        err_ff;
   logic [CW-1:0]        warn_ff;
   logic [CW-1:0]        k_ff;
   logic [MATCH_W-1:0]   m_ff;

   logic                 rsp_valid_ff;
   rec_type              rsp_rec_ff;
   logic                 rsp_rec_valid_ff;
   logic                 rsp_read_flag_ff;
   logic                 rsp_last_ff;
   logic [CNT_OUT_W-1:0] rsp_stored_ff;
   logic [CNT_OUT_W-1:0] rsp_unread_ff;
   logic [SEV_W-1:0]     rsp_highest_ff;

   logic                 out_free;
   logic                 rsp_load;
   logic                 scan_done;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic                 mem_wr_en;
   logic                 chk_match;
   logic                 chk_read;
   logic [AW-1:0]        wp_inc;
   logic [AW-1:0]        wp_prev;
   logic [AW-1:0]        slot_prev;
   logic                 drop_unread;
   logic [CW-1:0]        err_in;
   logic [CW-1:0]        warn_in;
   logic [CW-1:0]        unread_in;
   logic [CW-1:0]        held_in;
   logic [CW+5:0]        held_ext;
   logic [CW+5:0]        unread_ext;
   logic [SEV_W-1:0]     highest_now;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_done = (k_ff == held_ff) || (m_ff == CAP_CNT);

   // a response is loaded into the output register this cycle
   assign rsp_load  = ((state_ff == S_STATUS) || (state_ff == S_FLUSH)
                       || (state_ff == S_SCAN_CHK && chk_match && pend_valid_ff)) && out_free;

   assign wp_inc    = (wp_ff == LAST_SLOT) ? '0 : wp_ff + AW'(1);
   assign wp_prev   = (wp_ff == '0) ? LAST_SLOT : wp_ff - AW'(1);
   assign slot_prev = (slot_ff == '0) ? LAST_SLOT : slot_ff - AW'(1);

   assign mem_rd_en = (state_ff == S_IDLE && req_valid && opcode_type'(req_opcode) == OP_ADD)
                   || (state_ff == S_SCAN_RD && !scan_done);
   assign mem_rd_addr = (state_ff == S_IDLE) ? wp_ff : slot_ff;
   assign mem_wr_en   = (state_ff == S_ADD_WR);

   assign chk_match = all_ff || (rd_data_ff.severity == want_ff);
   assign chk_read  = (k_ff >= unread_ff);

   // an add into a log whose every record is unread displaces an unread record
   assign drop_unread = (unread_ff == DEPTH_CNT);
   always_comb begin
      err_in  = err_ff;
      warn_in = warn_ff;
      if (drop_unread) begin
         if (rd_data_ff.severity == SEV_ERROR)   err_in  = err_in - CW'(1);
         if (rd_data_ff.severity == SEV_WARNING) warn_in = warn_in - CW'(1);
      end
      if (new_rec_ff.severity == SEV_ERROR)   err_in  = err_in + CW'(1);
      if (new_rec_ff.severity == SEV_WARNING) warn_in = warn_in + CW'(1);
   end
   assign unread_in = drop_unread ? unread_ff : unread_ff + CW'(1);
   assign held_in   = (held_ff == DEPTH_CNT) ? held_ff : held_ff + CW'(1);

   assign held_ext    = {6'd0, held_ff};
   assign unread_ext  = {6'd0, unread_ff};
   assign highest_now = (err_ff != '0) ? SEV_ERROR :
                        (warn_ff != '0) ? SEV_WARNING : SEV_INFO;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         rec_mem[wp_ff] <= new_rec_ff;
      end
      if (mem_rd_en) begin
         rd_data_ff <= rec_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         wp_ff         <= '0;
         held_ff       <= '0;
         unread_ff     <= '0;
         err_ff        <= '0;
         warn_ff       <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  new_rec_ff.timestamp <= req_new_timestamp;
                  new_rec_ff.severity  <= req_new_severity;
                  new_rec_ff.modal     <= req_new_modal;
                  new_rec_ff.tag       <= req_new_tag;
                  all_ff  <= req_read_filter[FILT_W-1];
                  want_ff <= req_read_filter[SEV_W-1:0];
                  case (opcode_type'(req_opcode))
                     OP_ADD: begin
                        state_ff <= S_ADD_WR;
                     end
                     OP_READOUT: begin
                        slot_ff       <= wp_prev;
                        k_ff          <= '0;
                        m_ff          <= '0;
                        pend_valid_ff <= 1'b0;
                        state_ff      <= S_SCAN_RD;
                     end
                     OP_MARK_READ: begin
                        unread_ff <= '0;
                        err_ff    <= '0;
                        warn_ff   <= '0;
                        state_ff  <= S_STATUS;
                     end
                     OP_CLEAR: begin
                        wp_ff     <= '0;
                        held_ff   <= '0;
                        unread_ff <= '0;
                        err_ff    <= '0;
                        warn_ff   <= '0;
                        state_ff  <= S_STATUS;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_ADD_WR: begin
               err_ff    <= err_in;
               warn_ff   <= warn_in;
               unread_ff <= unread_in;
               held_ff   <= held_in;
               wp_ff     <= wp_inc;
               state_ff  <= S_STATUS;
            end
            S_STATUS: begin
               if (out_free) begin
                  rsp_rec_valid_ff <= 1'b0;
                  rsp_rec_ff       <= '0;
                  rsp_read_flag_ff <= 1'b0;
                  rsp_last_ff      <= 1'b1;
                  rsp_stored_ff    <= held_ext[CNT_OUT_W-1:0];
                  rsp_unread_ff    <= unread_ext[CNT_OUT_W-1:0];
                  rsp_highest_ff   <= highest_now;
                  state_ff         <= S_IDLE;
               end
            end
            S_SCAN_RD: begin
               state_ff <= scan_done ? S_FLUSH : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (!chk_match) begin
                  k_ff     <= k_ff + CW'(1);
                  slot_ff  <= slot_prev;
                  state_ff <= S_SCAN_RD;
               end else if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_rec_valid_ff <= 1'b1;
                     rsp_rec_ff       <= pend_rec_ff;
                     rsp_read_flag_ff <= pend_read_ff;
                     rsp_last_ff      <= 1'b0;
                     rsp_stored_ff    <= held_ext[CNT_OUT_W-1:0];
                     rsp_unread_ff    <= unread_ext[CNT_OUT_W-1:0];
                     rsp_highest_ff   <= highest_now;
                  end
                  pend_rec_ff   <= rd_data_ff;
                  pend_read_ff  <= chk_read;
                  pend_valid_ff <= 1'b1;
                  m_ff          <= m_ff + MATCH_W'(1);
                  k_ff          <= k_ff + CW'(1);
                  slot_ff       <= slot_prev;
                  state_ff      <= S_SCAN_RD;
               end
            end
            S_FLUSH: begin
               if (out_free) begin
                  rsp_rec_valid_ff <= pend_valid_ff;
                  rsp_rec_ff       <= pend_valid_ff ? pend_rec_ff : '0;
                  rsp_read_flag_ff <= pend_valid_ff & pend_read_ff;
                  rsp_last_ff      <= 1'b1;
                  rsp_stored_ff    <= held_ext[CNT_OUT_W-1:0];
                  rsp_unread_ff    <= unread_ext[CNT_OUT_W-1:0];
                  rsp_highest_ff   <= highest_now;
                  pend_valid_ff    <= 1'b0;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_valid   = rsp_rec_valid_ff;
   assign rsp_out_timestamp  = rsp_rec_ff.timestamp;
   assign rsp_out_severity   = rsp_rec_ff.severity;
   assign rsp_out_modal      = rsp_rec_ff.modal;
   assign rsp_out_read_flag  = rsp_read_flag_ff;
   assign rsp_out_tag        = rsp_rec_ff.tag;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_stored_count   = rsp_stored_ff;
   assign rsp_unread_count   = rsp_unread_ff;
   assign rsp_highest_unread = rsp_highest_ff;

   `ASSERT_PROP(a_unread_le_held, clock, reset, unread_ff <= held_ff)
   `ASSERT_PROP(a_sev_counts_fit, clock, reset,
      ({1'b0, err_ff} + {1'b0, warn_ff}) <= {1'b0, unread_ff})
   `ASSERT_PROP(a_one_request, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `ASSERT_NEVER(a_no_rw_clash, clock, reset, mem_wr_en && mem_rd_en)

endmodule

/* sim/severity_event_log_ring_core_tb.sv */
// Testbench for severity_event_log_ring_core: a mirror of the log ring predicts
// every response, which is checked field by field as it leaves the block.
// Depends on sevlog_pkg and the RTL of the core; no files or arguments are read.
module severity_event_log_ring_core_tb;
   import sevlog_pkg::*;

   localparam int RING_DEPTH   = 32;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_LIMIT = 10;

   localparam logic signed [FILT_W-1:0] FILT_ALL     = 3'b111;
   localparam logic signed [FILT_W-1:0] FILT_ALL_LOW = 3'b100;

   typedef struct packed {
      logic                 record_valid;
      logic [TS_W-1:0]      timestamp;
      logic [SEV_W-1:0]     severity;
      logic                 modal;
      logic                 read_flag;
      logic [TAG_W-1:0]     tag;
      logic                 last_of_run;
      logic [CNT_OUT_W-1:0] stored;
      logic [CNT_OUT_W-1:0] unread;
      logic [SEV_W-1:0]     highest;
   } log_result_type;

   class log_mirror_type;
      logic [TS_W-1:0]  stamp_mem [RING_DEPTH];
      logic [SEV_W-1:0] sev_mem   [RING_DEPTH];
      logic             modal_mem [RING_DEPTH];
      logic             read_mem  [RING_DEPTH];
      logic [TAG_W-1:0] tag_mem   [RING_DEPTH];
      int               wr_ptr;
      int               held;
      log_result_type   expected_results [$];
      int               op_count [4];
      int               overwrites;
      int               results_checked;
      int               errors;

      function new();
         wr_ptr = 0;
         held = 0;
         overwrites = 0;
         results_checked = 0;
         errors = 0;
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      function int slot(int k);
         return (wr_ptr + 2 * RING_DEPTH - 1 - k) % RING_DEPTH;
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction

      function void queue_expected(log_result_type r);
         expected_results.insert(expected_results.size(), r);
      endfunction

      function void note_request(opcode_type op, logic [TS_W-1:0] ts,
                                 logic [SEV_W-1:0] sev, logic modal,
                                 logic [TAG_W-1:0] tag,
                                 logic signed [FILT_W-1:0] filt);
         int          s;
         int          unread;
         int          emitted;
         logic [SEV_W-1:0] top;
         log_result_type r;
         bit          take_all;
         op_count[op]++;
         case (op)
            OP_ADD: begin
               s = wr_ptr;
               if (held == RING_DEPTH) overwrites++;
               stamp_mem[s] = ts;
               sev_mem[s]   = sev;
               modal_mem[s] = modal;
               read_mem[s]  = 1'b0;
               tag_mem[s]   = tag;
               wr_ptr = (s + 1) % RING_DEPTH;
               if (held < RING_DEPTH) held++;
            end
            OP_MARK_READ: begin
               for (int k = 0; k < held; k++) read_mem[slot(k)] = 1'b1;
            end
            OP_CLEAR: begin
               wr_ptr = 0;
               held = 0;
            end
            default: ;
         endcase
         unread = 0;
         top = SEV_INFO;
         for (int k = 0; k < held; k++) begin
            s = slot(k);
            if (!read_mem[s]) begin
               unread++;
               if (sev_mem[s] == SEV_ERROR) top = SEV_ERROR;
               else if (sev_mem[s] == SEV_WARNING && top != SEV_ERROR) top = SEV_WARNING;
            end
         end
         r = '0;
         r.stored  = CNT_OUT_W'(held);
         r.unread  = CNT_OUT_W'(unread);
         r.highest = top;
         if (op != OP_READOUT) begin
            r.last_of_run = 1'b1;
            queue_expected(r);
            return;
         end
         take_all = filt[FILT_W-1];
         emitted = 0;
         for (int k = 0; k < held && emitted < READOUT_CAP; k++) begin
            s = slot(k);
            if (!take_all && sev_mem[s] != filt[SEV_W-1:0]) continue;
            r.record_valid = 1'b1;
            r.timestamp    = stamp_mem[s];
            r.severity     = sev_mem[s];
            r.modal        = modal_mem[s];
            r.read_flag    = read_mem[s];
            r.tag          = tag_mem[s];
            r.last_of_run  = 1'b0;
            queue_expected(r);
            emitted++;
         end
         if (emitted == 0) begin
            r.last_of_run = 1'b1;
            queue_expected(r);
         end else begin
            r = expected_results.pop_back();
            r.last_of_run = 1'b1;
            queue_expected(r);
         end
      endfunction

      function void report(string what, log_result_type want, log_result_type got);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("%s (exp/got): rec %0d/%0d ts %h/%h sev %0d/%0d modal %0d/%0d",
                     what, want.record_valid, got.record_valid, want.timestamp,
                     got.timestamp, want.severity, got.severity, want.modal, got.modal);
            $display("   read %0d/%0d tag %h/%h last %0d/%0d held %0d/%0d",
                     want.read_flag, got.read_flag, want.tag, got.tag, want.last_of_run,
                     got.last_of_run, want.stored, got.stored);
            $display("   unread %0d/%0d top %0d/%0d",
                     want.unread, got.unread, want.highest, got.highest);
         end
      endfunction

      function void check_result(log_result_type got);
         log_result_type want;
         results_checked++;
         if (expected_results.size() == 0) begin
            report("unexpected response", '0, got);
            return;
         end
         want = expected_results.pop_front();
         if (got !== want) report("response mismatch", want, got);
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [OP_W-1:0]             req_opcode;
   logic [TS_W-1:0]             req_new_timestamp;
   logic [SEV_W-1:0]            req_new_severity;
   logic                        req_new_modal;
   logic [TAG_W-1:0]            req_new_tag;
   logic signed [FILT_W-1:0]    req_read_filter;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_record_valid;
   logic [TS_W-1:0]             rsp_out_timestamp;
   logic [SEV_W-1:0]            rsp_out_severity;
   logic                        rsp_out_modal;
   logic                        rsp_out_read_flag;
   logic [TAG_W-1:0]            rsp_out_tag;
   logic                        rsp_last_of_run;
   logic [CNT_OUT_W-1:0]        rsp_stored_count;
   logic [CNT_OUT_W-1:0]        rsp_unread_count;
   logic [SEV_W-1:0]            rsp_highest_unread;

   log_mirror_type mirror;
   int        send_idle_pct;
   int        recv_idle_pct;
   int        hold_left;
   int        cycle_count;
   log_result_type seen;

   severity_event_log_ring_core #(.LOG_DEPTH(RING_DEPTH)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("severity_event_log_ring_core verification failed");
         $finish;
      end
   end

   // response side: random back-pressure, or a long hold-off when asked
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.record_valid = rsp_record_valid;
         seen.timestamp    = rsp_out_timestamp;
         seen.severity     = rsp_out_severity;
         seen.modal        = rsp_out_modal;
         seen.read_flag    = rsp_out_read_flag;
         seen.tag          = rsp_out_tag;
         seen.last_of_run  = rsp_last_of_run;
         seen.stored       = rsp_stored_count;
         seen.unread       = rsp_unread_count;
         seen.highest      = rsp_highest_unread;
         mirror.check_result(seen);
      end
   end

   task automatic send_request(opcode_type op, logic [TS_W-1:0] ts,
                               logic [SEV_W-1:0] sev, logic modal,
                               logic [TAG_W-1:0] tag, logic signed [FILT_W-1:0] filt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_new_timestamp <= ts;
      req_new_severity  <= sev;
      req_new_modal     <= modal;
      req_new_tag       <= tag;
      req_read_filter   <= filt;
      do @(posedge clock); while (!req_ready);
      mirror.note_request(op, ts, sev, modal, tag, filt);
   endtask

   task automatic send_random(bit only_adds);
      opcode_type op;
      int         pick;
      pick = $urandom_range(99);
      if (only_adds || pick < 58) op = OP_ADD;
      else if (pick < 88)         op = OP_READOUT;
      else if (pick < 98)         op = OP_MARK_READ;
      else                        op = OP_CLEAR;
      send_request(op, {$urandom(), $urandom()}, SEV_W'($urandom_range(3)),
                   1'($urandom_range(1)), TAG_W'($urandom_range(16'hFFFF)),
                   FILT_W'($urandom_range(7)));
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (mirror.outstanding() != 0);
   endtask

   initial begin
      mirror = new();
      cycle_count = 0;
      hold_left = 0;
      send_idle_pct = 6;
      recv_idle_pct = 61;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_opcode        <= OP_ADD;
      req_new_timestamp <= '0;
      req_new_severity  <= SEV_INFO;
      req_new_modal     <= 1'b0;
      req_new_tag       <= '0;
      req_read_filter   <= FILT_ALL;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty log, extremes of the record fields, every filter
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, FILT_ALL);
      send_request(OP_MARK_READ, '0, SEV_INFO, 1'b0, '0, FILT_ALL);
      send_request(OP_CLEAR, '0, SEV_INFO, 1'b0, '0, FILT_ALL);
      send_request(OP_ADD, '0, SEV_INFO, 1'b0, 16'h0000, FILT_ALL);
      send_request(OP_ADD, '1, SEV_SUCCESS, 1'b1, 16'hFFFF, FILT_ALL);
      send_request(OP_ADD, 64'h5555_AAAA_5555_AAAA, SEV_WARNING, 1'b0, 16'h5A5A, FILT_ALL);
      send_request(OP_ADD, 64'hAAAA_5555_AAAA_5555, SEV_ERROR, 1'b1, 16'hA5A5, FILT_ALL);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, FILT_ALL);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, FILT_ALL_LOW);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, 3'sd0);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, 3'sd1);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, 3'sd2);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, 3'sd3);
      send_request(OP_MARK_READ, '0, SEV_INFO, 1'b0, '0, FILT_ALL);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, FILT_ALL);
      send_request(OP_ADD, 64'd1000, SEV_WARNING, 1'b1, 16'h1234, FILT_ALL);
      send_request(OP_ADD, 64'd1001, SEV_SUCCESS, 1'b0, 16'h4321, FILT_ALL);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, 3'sd3);
      send_request(OP_CLEAR, '0, SEV_INFO, 1'b0, '0, FILT_ALL);
      send_request(OP_READOUT, '0, SEV_INFO, 1'b0, '0, 3'sd2);
      send_request(OP_ADD, 64'd7, SEV_INFO, 1'b1, 16'h0001, FILT_ALL);
      send_request(OP_ADD, 64'hFFFF_0000_FFFF_0000, SEV_ERROR, 1'b0, 16'h8000, FILT_ALL);

      // fill past the ring depth so that adds overwrite, then mixed traffic
      for (int i = 0; i < 45; i++) send_random(1'b1);
      for (int i = 0; i < 52; i++) send_random(1'b0);

      send_idle_pct = 61;
      recv_idle_pct = 6;
      for (int i = 0; i < 97; i++) begin
         if (i == 40) wait_for_quiet();
         send_random(1'b0);
      end

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 96; i++) begin
         if (i == 30) hold_left = HOLD_CYCLES;
         send_random(1'b0);
      end

      req_valid <= 1'b0;
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.outstanding() != 0) mirror.errors++;

      $display("requests: %0d adds, %0d readouts, %0d mark-read, %0d clears",
               mirror.op_count[OP_ADD], mirror.op_count[OP_READOUT],
               mirror.op_count[OP_MARK_READ], mirror.op_count[OP_CLEAR]);
      $display("responses checked: %0d, oldest-record overwrites: %0d, failures: %0d",
               mirror.results_checked, mirror.overwrites, mirror.errors);
      if (mirror.errors == 0) begin
         $display("severity_event_log_ring_core verification clean");
      end else begin
         $display("severity_event_log_ring_core verification failed");
      end
      $finish;
   end

endmodule
